// ===== src/bfks_pkg.sv =====
// shared types and constants for the block floor key search unit
`default_nettype none

package bfks_pkg;

  // field widths fixed by the interface
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned KEY_HALF_W = 64;
  localparam int unsigned KEY_W      = 2 * KEY_HALF_W;

  // register map, index taken from paddr[2]
  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 9'd1;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [0:0] {
    S_IDLE,
    S_STEP
  } srch_state_t;

endpackage

`default_nettype wire

// ===== src/bfks_key_mem.sv =====
// first-key table: one write port, one registered read port
`default_nettype none

module bfks_key_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en_i,
  input  wire logic [AW-1:0]              wr_addr_i,
  input  wire logic [bfks_pkg::KEY_W-1:0] wr_data_i,
  input  wire logic                       rd_en_i,
  input  wire logic [AW-1:0]              rd_addr_i,
  output      logic [bfks_pkg::KEY_W-1:0] rd_data_o
);
  import bfks_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      rd_data_r <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_r;

endmodule

`default_nettype wire

// ===== src/bfks_search.sv =====
// binary floor search: bounds, probe address and result registers
`default_nettype none

module bfks_search #(
  parameter int unsigned AW = 8,
  parameter int unsigned BW = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go_i,
  input  wire logic [bfks_pkg::KEY_W-1:0] key_i,
  input  wire logic [BW-1:0]              count_i,
  input  wire logic [bfks_pkg::KEY_W-1:0] rd_data_i,
  output      logic                       rd_en_o,
  output      logic [AW-1:0]              rd_addr_o,
  output      logic                       busy_o,
  output      logic                       res_valid_o,
  output      logic [bfks_pkg::IDX_W-1:0] res_index_o,
  output      logic                       res_flag_o
);
  import bfks_pkg::*;

  srch_state_t state_r, state_nxt;

  logic [KEY_W-1:0] key_r;
  logic [BW-1:0]    lo_r, hi_r, mid_r;
  logic [BW-1:0]    lo_c, hi_c, mid_c;
  logic             hit_c, done_c, cmp_lt, cmp_eq;
  logic             active, finish;
  logic [BW+IDX_W-1:0] lo_ext;

  logic             res_valid_r;
  logic [IDX_W-1:0] res_index_r;
  logic             res_flag_r;

  assign cmp_lt = rd_data_i < key_r;
  assign cmp_eq = rd_data_i == key_r;

  // next bounds; lower bound starts at -1 (all ones)
  always_comb begin
    lo_c  = lo_r;
    hi_c  = hi_r;
    hit_c = 1'b0;
    case (state_r)
      S_IDLE: begin
        lo_c = '1;
        hi_c = count_i - BW'(1);
      end
      S_STEP: begin
        if (cmp_eq) begin
          lo_c  = mid_r;
          hi_c  = mid_r;
          hit_c = 1'b1;
        end else if (cmp_lt) begin
          lo_c = mid_r;
        end else begin
          hi_c = mid_r - BW'(1);
        end
      end
      default: begin
        lo_c = lo_r;
      end
    endcase
    mid_c  = lo_c + ((hi_c - lo_c + BW'(1)) >> 1);
    done_c = (lo_c == hi_c);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (go_i && !done_c) state_nxt = S_STEP;
      S_STEP:  if (done_c) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    active = 1'b0;
    case (state_r)
      S_IDLE:  active = go_i;
      S_STEP:  active = 1'b1;
      default: active = 1'b0;
    endcase
    rd_en_o = active && !done_c;
    finish  = active && done_c;
    busy_o  = (state_r != S_IDLE);
  end

  assign rd_addr_o = mid_c[AW-1:0];
  assign lo_ext    = {{IDX_W{1'b0}}, lo_c};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lo_r        <= '0;
      hi_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= finish;
      if (active) begin
        lo_r <= lo_c;
        hi_r <= hi_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      mid_r <= mid_c;
    end
    if (state_r == S_IDLE && go_i) begin
      key_r <= key_i;
    end
    if (finish) begin
      // negative lower bound: key below every entry
      res_index_r <= lo_c[BW-1] ? '0 : lo_ext[IDX_W-1:0];
      res_flag_r  <= hit_c || lo_c[BW-1];
    end
  end

  assign res_valid_o = res_valid_r;
  assign res_index_o = res_index_r;
  assign res_flag_o  = res_flag_r;

endmodule

`default_nettype wire

// ===== src/block_floor_key_search_unit.sv =====
// top level: block floor key search unit
//
//  port group   dir   role
//  start/in_*   in    load beat (entry write) or search beat, taken when start & !busy
//  out_*        out   one result per search, out_valid high for a single cycle
//  p* (apb)     both  block_count register at byte address 0
//
// a load gives no result; busy stays low
// a search holds busy while it probes the key table; the result is registered
// at the end of the last probe step and shown in the cycle busy drops; with
// block_count zero it comes the next cycle
// the probe rate is set by the single read port of the table memory
// rst_n is synchronous; the table is not cleared and holds garbage until loaded
`default_nettype none

module block_floor_key_search_unit #(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned KEY_BYTES  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire logic                            in_req_type,
  input  wire logic [bfks_pkg::IDX_W-1:0]      in_entry_index,
  input  wire logic [bfks_pkg::KEY_HALF_W-1:0] in_key_high,
  input  wire logic [bfks_pkg::KEY_HALF_W-1:0] in_key_low,
  output      logic                            out_valid,
  output      logic [bfks_pkg::IDX_W-1:0]      out_block_index,
  output      logic                            out_no_scan_needed,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output      logic [31:0]                     prdata,
  output      logic                            pready
);
  import bfks_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned BW = $clog2(MAX_BLOCKS + 1) + 1;
  localparam int unsigned CW = BW + COUNT_W;
  // only the leading KEY_BYTES bytes of a key take part
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_BYTES);

  logic [COUNT_W-1:0] block_count_r;
  logic               cfg_wr;
  logic [CW-1:0]      count_ext;
  logic [BW-1:0]      count_sat;

  logic               accept, load_wr, search_go;
  logic [KEY_W-1:0]   key_masked;
  logic [AW+IDX_W-1:0] entry_ext;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [KEY_W-1:0]   rd_data;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCK_COUNT);
  assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? 32'(block_count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= BLOCK_COUNT_RESET;
    end else if (cfg_wr) begin
      block_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  // counts above the table size clamp to it
  assign count_ext = CW'(block_count_r);
  assign count_sat = (count_ext > CW'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : count_ext[BW-1:0];

  assign accept     = start && !busy;
  assign key_masked = {in_key_high, in_key_low} & KEY_MASK;
  assign entry_ext  = (AW + IDX_W)'(in_entry_index);
  assign load_wr    = accept && (in_req_type == REQ_LOAD) &&
                      ((AW + IDX_W)'(in_entry_index) < (AW + IDX_W)'(MAX_BLOCKS));
  assign search_go  = accept && (in_req_type == REQ_SEARCH);

  bfks_key_mem #(
    .DEPTH (MAX_BLOCKS),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en_i   (load_wr),
    .wr_addr_i (entry_ext[AW-1:0]),
    .wr_data_i (key_masked),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bfks_search #(
    .AW (AW),
    .BW (BW)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .go_i        (search_go),
    .key_i       (key_masked),
    .count_i     (count_sat),
    .rd_data_i   (rd_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .busy_o      (busy),
    .res_valid_o (out_valid),
    .res_index_o (out_block_index),
    .res_flag_o  (out_no_scan_needed)
  );

endmodule

`default_nettype wire

// ===== src/bfks_checker.sv =====
// port-level checks for the block floor key search unit, bound to the top
`default_nettype none

module bfks_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_req_type,
  input wire logic out_valid,
  input wire logic psel,
  input wire logic pready
);
  import bfks_pkg::*;

  // a load beat never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_LOAD |=> !out_valid)
    else $error("result after load beat");

  // a result is shown only once the search has released busy
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // busy only rises on an accepted search beat
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) && $past(rst_n) |-> $past(start) && $past(in_req_type) == REQ_SEARCH)
    else $error("busy without search beat");

  // end of a search always delivers its result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("search ended without result");

  // apb never stalls
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    psel |-> pready)
    else $error("pready low");

endmodule

bind block_floor_key_search_unit bfks_checker u_chk (.*);

`default_nettype wire
